/* design/cmlm_pkg.sv */
// ----------------------------------------------------------------------------
// cmlm_pkg
// Shared types and character codes for the comment and literal masker.
// ----------------------------------------------------------------------------
package cmlm_pkg;

  localparam logic       OP_CHAR      = 1'b0;
  localparam logic       OP_EOL       = 1'b1;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic [1:0] count;
    entry_t     first;
    entry_t     second;
  } scan_result_t;

endpackage

/* design/cmlm_in_if.sv */
// ----------------------------------------------------------------------------
// cmlm_in_if
// Input stream: one source byte or end-of-line marker per transfer.
// ----------------------------------------------------------------------------
interface cmlm_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] character;

  modport source (output valid, output operation, output character, input ready);
  modport sink (input valid, input operation, input character, output ready);
endinterface

/* design/cmlm_out_if.sv */
// ----------------------------------------------------------------------------
// cmlm_out_if
// Output stream: one masked byte per transfer.
// ----------------------------------------------------------------------------
interface cmlm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] masked_char;
  logic       last_of_run;

  modport source (output valid, output masked_char, output last_of_run, input ready);
  modport sink (input valid, input masked_char, input last_of_run, output ready);
endinterface

/* design/cmlm_scanner.sv */
// ----------------------------------------------------------------------------
// cmlm_scanner
// Lexical state flags and the per-item masking decision (zero to two bytes).
// ----------------------------------------------------------------------------
module cmlm_scanner (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  enable,
  input  logic                  operation,
  input  logic [7:0]            character,
  output cmlm_pkg::scan_result_t result
);
  import cmlm_pkg::*;

  logic block_open, block_open_next;
  logic in_line_comment, in_line_comment_next;
  logic in_string_literal, in_string_literal_next;
  logic in_char_literal, in_char_literal_next;
  logic escape_active, escape_active_next;
  logic star_seen, star_seen_next;
  logic slash_pending, slash_pending_next;

  logic [7:0]   plain_ch;
  logic [7:0]   quote;
  scan_result_t res;

  assign plain_ch = (character == CH_DQUOTE || character == CH_SQUOTE) ? CH_SPACE : character;
  assign quote    = in_string_literal ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    block_open_next        = block_open;
    in_line_comment_next   = in_line_comment;
    in_string_literal_next = in_string_literal;
    in_char_literal_next   = in_char_literal;
    escape_active_next     = escape_active;
    star_seen_next         = star_seen;
    slash_pending_next     = slash_pending;
    res.count              = 2'd0;
    res.first              = '{ch: CH_SPACE, last: 1'b0};
    res.second             = '{ch: CH_SPACE, last: 1'b0};

    if (operation == OP_EOL) begin
      if (slash_pending) begin
        res.count    = 2'd1;
        res.first.ch = CH_SLASH;
      end
      in_line_comment_next   = 1'b0;
      in_string_literal_next = 1'b0;
      in_char_literal_next   = 1'b0;
      escape_active_next     = 1'b0;
      star_seen_next         = 1'b0;
      slash_pending_next     = 1'b0;
    end else if (in_line_comment) begin
      res.count = 2'd1;
    end else if (block_open) begin
      if (star_seen && character == CH_SLASH) begin
        block_open_next = 1'b0;
        star_seen_next  = 1'b0;
      end else begin
        star_seen_next = (character == CH_STAR);
      end
      res.count = 2'd1;
    end else if (in_string_literal || in_char_literal) begin
      if (!escape_active && character == quote) begin
        in_string_literal_next = 1'b0;
        in_char_literal_next   = 1'b0;
      end
      escape_active_next = !escape_active && character == CH_BACKSLASH;
      res.count          = 2'd1;
    end else if (slash_pending) begin
      slash_pending_next = 1'b0;
      res.count          = 2'd2;
      if (character == CH_SLASH) begin
        in_line_comment_next = 1'b1;
      end else if (character == CH_STAR) begin
        block_open_next = 1'b1;
        star_seen_next  = 1'b0;
      end else begin
        res.first.ch           = CH_SLASH;
        res.second.ch          = plain_ch;
        escape_active_next     = 1'b0;
        in_string_literal_next = (character == CH_DQUOTE);
        in_char_literal_next   = (character == CH_SQUOTE);
      end
    end else if (character == CH_SLASH) begin
      escape_active_next = 1'b0;
      slash_pending_next = 1'b1;
    end else begin
      res.count              = 2'd1;
      res.first.ch           = plain_ch;
      escape_active_next     = 1'b0;
      in_string_literal_next = (character == CH_DQUOTE);
      in_char_literal_next   = (character == CH_SQUOTE);
    end

    res.first.last  = (res.count == 2'd1);
    res.second.last = (res.count == 2'd2);
    if (!enable) begin
      res.count = 2'd0;
    end
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_open        <= 1'b0;
      in_line_comment   <= 1'b0;
      in_string_literal <= 1'b0;
      in_char_literal   <= 1'b0;
      escape_active     <= 1'b0;
      star_seen         <= 1'b0;
      slash_pending     <= 1'b0;
    end else if (enable) begin
      block_open        <= block_open_next;
      in_line_comment   <= in_line_comment_next;
      in_string_literal <= in_string_literal_next;
      in_char_literal   <= in_char_literal_next;
      escape_active     <= escape_active_next;
      star_seen         <= star_seen_next;
      slash_pending     <= slash_pending_next;
    end
  end

endmodule

/* design/cmlm_out_queue.sv */
// ----------------------------------------------------------------------------
// cmlm_out_queue
// Small result queue: takes up to two bytes per cycle, gives one per transfer.
// ----------------------------------------------------------------------------
module cmlm_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  cmlm_pkg::scan_result_t push,
  output logic                   room,
  cmlm_out_if.source             result
);
  import cmlm_pkg::*;

  entry_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QPTR_W-1:0]   wr_ptr_second;
  logic                pop;
  logic [QCNT_W-1:0]   count_next;

  assign room          = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop           = result.valid && result.ready;
  assign wr_ptr_second = wr_ptr + QPTR_W'(1);
  assign count_next    = count + QCNT_W'(push.count) - QCNT_W'(pop);

  assign result.valid       = (count != '0);
  assign result.masked_char = entries[rd_ptr].ch;
  assign result.last_of_run = entries[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

/* design/comment_and_literal_masker_core.sv */
// ----------------------------------------------------------------------------
// comment_and_literal_masker_core
// Masks comments and string/char literals in a C source byte stream.
// ----------------------------------------------------------------------------
// path: a result passes the input register and then the result queue before it
//   is offered, and it transfers when the output is ready
// throughput: one item per cycle while the result queue has room for two bytes;
//   the output moves one byte per cycle, so an item giving two bytes takes two output transfers (4-entry queue)
// reset: synchronous, clears all lexical flags and empties the input register
//   and the result queue
module comment_and_literal_masker_core (
  input  logic       clk,
  input  logic       rst,
  cmlm_in_if.sink    item,
  cmlm_out_if.source result
);
  import cmlm_pkg::*;

  logic         in_valid;
  logic         in_operation;
  logic [7:0]   in_character;
  logic         room;
  logic         advance;
  scan_result_t scan;

  assign advance    = in_valid && room;
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_operation <= item.operation;
      in_character <= item.character;
    end
  end

  cmlm_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .enable    (advance),
    .operation (in_operation),
    .character (in_character),
    .result    (scan)
  );

  cmlm_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (scan),
    .room   (room),
    .result (result)
  );

endmodule

/* test/cmlm_masking_checker.sv */
// ----------------------------------------------------------------------------
// cmlm_masking_checker
// Watches both streams of the masker, predicts the masked bytes of every
// accepted input transfer and compares each output transfer, in order, against
// the oldest predicted byte and its end-of-run mark.
// ----------------------------------------------------------------------------
module cmlm_masking_checker (
  input  logic clk,
  input  logic rst,
  cmlm_in_if   item,
  cmlm_out_if  result,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cmlm_pkg::*;

  logic   in_block;
  logic   in_line;
  logic   in_str;
  logic   in_chr;
  logic   escaped;
  logic   star_seen;
  logic   slash_held;
  entry_t expected_bytes[$];
  entry_t want;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // byte outside comments and literals with no slash held
  function automatic logic [7:0] open_or_pass(input logic [7:0] c);
    escaped = 1'b0;
    if (c == CH_DQUOTE) begin
      in_str = 1'b1;
      return CH_SPACE;
    end
    if (c == CH_SQUOTE) begin
      in_chr = 1'b1;
      return CH_SPACE;
    end
    return c;
  endfunction

  task automatic predict_mask(input logic op, input logic [7:0] c);
    logic [7:0] bytes_out [2];
    logic [7:0] quote;
    int         n;
    n = 0;
    if (op == OP_EOL) begin
      if (slash_held) begin
        bytes_out[n] = CH_SLASH;
        n++;
      end
      in_line    = 1'b0;
      in_str     = 1'b0;
      in_chr     = 1'b0;
      escaped    = 1'b0;
      star_seen  = 1'b0;
      slash_held = 1'b0;
    end else if (in_line) begin
      bytes_out[n] = CH_SPACE;
      n++;
    end else if (in_block) begin
      if (star_seen && c == CH_SLASH) begin
        in_block  = 1'b0;
        star_seen = 1'b0;
      end else begin
        star_seen = (c == CH_STAR);
      end
      bytes_out[n] = CH_SPACE;
      n++;
    end else if (in_str || in_chr) begin
      quote = in_str ? CH_DQUOTE : CH_SQUOTE;
      if (!escaped && c == quote) begin
        in_str = 1'b0;
        in_chr = 1'b0;
      end
      escaped = !escaped && c == CH_BACKSLASH;
      bytes_out[n] = CH_SPACE;
      n++;
    end else if (slash_held) begin
      slash_held = 1'b0;
      if (c == CH_SLASH || c == CH_STAR) begin
        if (c == CH_SLASH) begin
          in_line = 1'b1;
        end else begin
          in_block  = 1'b1;
          star_seen = 1'b0;
        end
        bytes_out[0] = CH_SPACE;
        bytes_out[1] = CH_SPACE;
      end else begin
        bytes_out[0] = CH_SLASH;
        bytes_out[1] = open_or_pass(c);
      end
      n = 2;
    end else if (c == CH_SLASH) begin
      escaped    = 1'b0;
      slash_held = 1'b1;
    end else begin
      bytes_out[n] = open_or_pass(c);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      expected_bytes.insert(expected_bytes.size(),
                            entry_t'{ch: bytes_out[i], last: (i == n - 1)});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_block   = 1'b0;
      in_line    = 1'b0;
      in_str     = 1'b0;
      in_chr     = 1'b0;
      escaped    = 1'b0;
      star_seen  = 1'b0;
      slash_held = 1'b0;
      expected_bytes.delete();
    end else begin
      // outputs first: a byte leaving now belongs to an earlier input
      if (result.valid && result.ready) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("output transfer %h/%b with nothing expected",
                                  result.masked_char, result.last_of_run));
        end else begin
          want = expected_bytes.pop_front();
          if (result.masked_char !== want.ch)
            flag_mismatch($sformatf("masked_char got %h expected %h",
                                    result.masked_char, want.ch));
          if (result.last_of_run !== want.last)
            flag_mismatch($sformatf("last_of_run got %b expected %b",
                                    result.last_of_run, want.last));
        end
      end
      if (item.valid && item.ready)
        predict_mask(item.operation, item.character);
    end
    pending <= expected_bytes.size();
  end

endmodule

/* test/comment_and_literal_masker_core_tb.sv */
// ----------------------------------------------------------------------------
// comment_and_literal_masker_core_tb
// Feeds the masker short directed source lines covering comment openers and
// closers, quotes, escapes and held slashes, then random source-like lines
// under several idle and stall patterns; the checker judges every output.
// ----------------------------------------------------------------------------
module comment_and_literal_masker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmlm_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   sender_idle_pct = 0;
  int   sink_stall_pct  = 0;
  int   quiet_cycles    = 0;
  int   errors;
  int   pending;

  cmlm_in_if  item_ch ();
  cmlm_out_if result_ch ();

  comment_and_literal_masker_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  cmlm_masking_checker mask_check (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // no transfer on either side for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("comment_and_literal_masker_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.character <= c;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_CHAR, s[i]);
    send_item(OP_EOL, 8'($urandom_range(0, 255)));
  endtask

  // weighted towards the bytes that steer the lexer
  function automatic logic [7:0] source_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return CH_SLASH;
    if (r < 24) return CH_STAR;
    if (r < 32) return CH_DQUOTE;
    if (r < 38) return CH_SQUOTE;
    if (r < 44) return CH_BACKSLASH;
    if (r < 52) return 8'($urandom_range(0, 255));
    if (r < 62) return CH_SPACE;
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  task automatic send_random_lines(input int count);
    int  sent;
    int  len;
    bit  noise;
    sent = 0;
    while (sent < count) begin
      noise = ($urandom_range(0, 9) == 0);
      len   = $urandom_range(0, 14);
      for (int j = 0; j < len; j++)
        send_item(OP_CHAR, noise ? 8'($urandom_range(0, 255)) : source_byte());
      send_item(OP_EOL, 8'($urandom_range(0, 255)));
      sent += len + 1;
    end
  endtask

  initial begin
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_CHAR;
    item_ch.character = 8'h00;
    result_ch.ready   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // opening star does not close, star before end of line does not close
    send_line("/*/*");
    send_line("/*/q");
    send_line("//'");
    // escaped quote in char literal, slash before quote, escaped backslash
    send_line("'\\''/\"\\\\\"");
    // zero and top bytes, slash released by a byte and by end of line
    send_item(OP_CHAR, 8'h00);
    send_item(OP_CHAR, CH_SLASH);
    send_item(OP_CHAR, 8'hFF);
    send_line("/");

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 76; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin sender_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      send_random_lines(RANDOM_ITEMS / 4);
    end
    item_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("comment_and_literal_masker_core verification clean");
    end else begin
      $display("comment_and_literal_masker_core verification failed");
    end
    $finish;
  end

endmodule
